// ===== sv/cpv_pkg.sv =====
package cpv_pkg;

  localparam int unsigned MaxPduBytes = 131072;
  localparam int unsigned CntW = 18;

  typedef enum logic [2:0] {
    KIND_ACK   = 3'd0,
    KIND_SLIST = 3'd1,
    KIND_MESS  = 3'd2,
    KIND_QUIT  = 3'd3,
    KIND_JOIN  = 3'd4,
    KIND_PJOIN = 3'd5,
    KIND_PART  = 3'd6,
    KIND_UNK   = 3'd7
  } kind_e;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic [2:0]      func;
    logic [7:0]      data_byte;
    logic            last;
    logic            first;
    logic            over;
    logic [CntW-1:0] idx;
  } cpv_item_t;

  function automatic logic [1:0] pads_for(input logic [15:0] len);
    pads_for = 2'(3'd4 - {1'b0, len[1:0]});
  endfunction

endpackage

// ===== sv/cpv_front.sv =====
module cpv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tlast,
  input  logic [2:0]         s_tuser,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output cpv_pkg::cpv_item_t q_item_o
);
  import cpv_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  cpv_item_t       item_q;
  logic            vld_q;
  logic            take;

  assign s_tready  = !vld_q || q_ready_i;
  assign take      = s_tvalid && s_tready;
  assign q_valid_o = vld_q;
  assign q_item_o  = item_q;

  // Byte index is tracked here so the back only checks positions.
  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      if (s_tlast) cnt_d = '0;
      else if (cnt_q < CntW'(MaxPduBytes)) cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (take) vld_q <= 1'b1;
      else if (q_ready_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func      <= s_tuser;
      item_q.data_byte <= s_tdata;
      item_q.last      <= s_tlast;
      item_q.first     <= (cnt_q == '0);
      item_q.over      <= (cnt_q >= CntW'(MaxPduBytes));
      item_q.idx       <= cnt_q;
    end
  end

endmodule

// ===== sv/cpv_back.sv =====
module cpv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         pad_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  cpv_pkg::cpv_item_t q_item_i,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata
);
  import cpv_pkg::*;

  logic [2:0]      kind_q;
  logic [15:0]     la_q, lb_q, rl_q;
  logic [7:0]      sum_q, rnl_q;
  logic            fail_q, pp_q, rc_q;
  logic [8:0]      nc_q;
  logic [CntW-1:0] rs_q, n_q;
  logic            ov_q, res_q;

  logic [2:0]      k;
  logic [15:0]     la, lb, rl;
  logic [7:0]      sum, rnl, b;
  logic            fail, pp, rc;
  logic [8:0]      nc;
  logic [CntW-1:0] rs, i;
  logic [CntW+1:0] a, e, n, t;
  logic [8:0]      s9;
  logic            ispad, verd, take;

  assign take      = q_valid_i && q_ready_o;
  assign q_ready_o = !ov_q || m_tready;
  assign m_tvalid  = ov_q;
  assign m_tdata   = {7'd0, res_q};

  always_comb begin
    b = q_item_i.data_byte;
    i = q_item_i.idx;
    ispad = (b == pad_i);
    if (q_item_i.first) begin
      k = q_item_i.func; la = '0; lb = '0; sum = '0; fail = 1'b0; pp = 1'b0;
      nc = '0; rl = '0; rs = CntW'(4); rnl = '0; rc = 1'b0;
    end else begin
      k = kind_q; la = la_q; lb = lb_q; sum = sum_q; fail = fail_q; pp = pp_q;
      nc = nc_q; rl = rl_q; rs = rs_q; rnl = rnl_q; rc = rc_q;
    end
    a = '0; e = '0; s9 = '0;
    if (q_item_i.over) begin
      fail = 1'b1;
    end else begin
      s9 = {1'b0, sum} + {1'b0, b};
      sum = (s9 >= 9'd255) ? 8'(s9 - 9'd255) : s9[7:0];
      unique case (kind_e'(k))
        KIND_ACK: if (i == 1 && !ispad) fail = 1'b1;
        KIND_QUIT: if (i >= 1 && i <= 3 && !ispad) fail = 1'b1;
        KIND_JOIN: if ((i == 2 || i == 3) && !ispad) fail = 1'b1;
        KIND_SLIST: begin
          if (i == 1 && !ispad) fail = 1'b1;
          if (i == 2) rl = {b, 8'd0};
          if (i == 3) begin
            rl = {rl[15:8], b};
            if (rl == 0) rc = 1'b1;
          end
          if (i >= 4 && !rc && rl != 0) begin
            if ({2'b0, i} == {2'b0, rs} + 20'd7) rnl = b;
            if ({2'b0, i} >= {2'b0, rs} + 20'd7) begin
              a = {2'b0, rs} + 20'd8 + {12'd0, rnl};
              e = a + {18'd0, pads_for({8'd0, rnl})};
              if ({2'b0, i} >= a && {2'b0, i} < e && !ispad) fail = 1'b1;
              if ({2'b0, i} + 20'd1 == e) begin
                rs = e[CntW-1:0];
                rl = rl - 1'b1;
                if (rl == 0) rc = 1'b1;
              end
            end
          end
        end
        KIND_MESS: begin
          if ((i == 1 || i == 6 || i == 7) && !ispad) fail = 1'b1;
          if (i == 2) lb = {8'd0, b};
          if (i == 4) la = {b, 8'd0};
          if (i == 5) la = {la[15:8], b};
          if (i >= 12) begin
            a = 20'd12 + {4'd0, la};
            e = a + {18'd0, pads_for(la)};
            if ({2'b0, i} >= a && {2'b0, i} < e && !ispad) fail = 1'b1;
            if ({2'b0, i} >= e + {4'd0, lb} && !ispad) fail = 1'b1;
          end
        end
        KIND_PJOIN: begin
          if (i == 1) la = {8'd0, b};
          if ((i == 2 || i == 3) && !ispad) fail = 1'b1;
          if (i >= 2 && {2'b0, i} >= 20'd8 + {4'd0, la} && !ispad) fail = 1'b1;
        end
        KIND_PART: begin
          if (i == 1) lb = {8'd0, b};
          if (i == 2) la = {b, 8'd0};
          if (i == 3) la = {la[15:8], b};
          if (i == 4 && ispad && lb > 0) fail = 1'b1;
          if (i >= 4) begin
            if ({2'b0, i} < 20'd4 + {4'd0, la}) begin
              if (ispad) begin
                if (nc < 9'd511) nc = nc + 1'b1;
                if (pp) fail = 1'b1;
                pp = 1'b1;
              end else pp = 1'b0;
            end else if (!ispad) fail = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Verdict on the byte count after this byte.
    n = q_item_i.over ? 20'(MaxPduBytes) : {2'b0, i} + 20'd1;
    t = '0;
    verd = 1'b0;
    unique case (kind_e'(k))
      KIND_ACK, KIND_QUIT: verd = (n == 20'd4);
      KIND_JOIN: verd = (n >= 20'd4);
      KIND_SLIST: verd = (n >= 20'd4) && rc;
      KIND_MESS: begin
        t = 20'd12 + {4'd0, la} + {18'd0, pads_for(la)} + {4'd0, lb}
          + {18'd0, pads_for(lb)};
        verd = (n >= 20'd16) && (n == t) && (sum == 0);
      end
      KIND_PJOIN: begin
        t = 20'd8 + {4'd0, la} + {18'd0, pads_for(la)};
        verd = (n >= 20'd2) && (n == t);
      end
      KIND_PART: begin
        t = 20'd4 + {4'd0, la} + {18'd0, pads_for(la)};
        verd = (n >= 20'd4) && (n == t) && (nc == lb[8:0]) && (lb[15:9] == 0);
      end
      default: verd = 1'b0;
    endcase
    verd = verd && !fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      kind_q <= '0; la_q <= '0; lb_q <= '0; sum_q <= '0; fail_q <= 1'b0;
      pp_q <= 1'b0; nc_q <= '0; rl_q <= '0; rs_q <= CntW'(4); rnl_q <= '0;
      rc_q <= 1'b0; n_q <= '0;
    end else begin
      if (take && q_item_i.last) ov_q <= 1'b1;
      else if (m_tready) ov_q <= 1'b0;
      if (take) begin
        kind_q <= k; la_q <= la; lb_q <= lb; sum_q <= sum; fail_q <= fail;
        pp_q <= pp; nc_q <= nc; rl_q <= rl; rs_q <= rs; rnl_q <= rnl;
        rc_q <= rc; n_q <= n[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && q_item_i.last) res_q <= verd;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_tready) |=> ov_q) else $error("verdict dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_tready) |-> !q_ready_o) else $error("took byte over pending verdict");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxPduBytes)) else $error("byte count overflow");

endmodule

// ===== sv/chat_pdu_validator.sv =====
// Channel  | Signals                                   | Content
// s_axis   | s_tvalid s_tready s_tdata s_tlast s_tuser | one PDU byte, kind on tuser
// m_axis   | m_tvalid m_tready m_tdata                 | verdict, one per PDU
// cfg      | cfg_valid_i cfg_ready_o cfg_data_i        | pad value
// One byte per cycle, stalling only while an untaken verdict blocks the back;
// a byte enters the front register, then the back updates the PDU checks.
// The verdict is registered in the back once the last byte leaves the front
// register and holds until taken. Reset is async, low.
module chat_pdu_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] data_byte
  input  logic        s_tlast,
  input  logic [2:0]  s_tuser,  // [2:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [0] valid_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import cpv_pkg::*;

  logic      q_valid, q_ready;
  cpv_item_t q_item;
  logic [7:0] pad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_q <= '0;
    else if (cfg_valid_i) pad_q <= cfg_data_i;
  end

  cpv_front u_front (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tlast, .s_tuser,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  cpv_back u_back (
    .clk_i, .rst_ni, .pad_i(pad_q), .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_item_i(q_item), .m_tvalid, .m_tready, .m_tdata
  );

endmodule

// ===== dv/tb.sv =====
module tb;
  import cpv_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;  // [7:0] data_byte
  logic        s_tlast = 1'b0;
  logic [2:0]  s_tuser = '0;  // [2:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // [0] valid_res
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  chat_pdu_validator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  pad_q;
  int unsigned n_bytes, len_a, len_b, sum255, names, recs_left, rec_start, rec_nlen;
  kind_e       pdu_kind;
  bit          bad, last_pad, recs_done;
  bit          verdict_q[$];
  bit          errors = 0;
  bit          quiet = 0;
  longint      cycles = 0;
  logic [7:0]  pdu[$];

  function automatic int unsigned pad_count(int unsigned len);
    return (4 - (len & 3)) & 3;
  endfunction

  function automatic void clear_pdu();
    n_bytes = 0; pdu_kind = KIND_ACK; len_a = 0; len_b = 0; sum255 = 0;
    bad = 0; last_pad = 0; names = 0; recs_left = 0; rec_start = 4;
    rec_nlen = 0; recs_done = 0;
  endfunction

  function automatic void chk_pad(int unsigned b);
    if (b != pad_q) bad = 1;
  endfunction

  function automatic void absorb(int unsigned i, int unsigned b);
    int unsigned a, e;
    sum255 = (sum255 + b) % 255;
    case (pdu_kind)
      KIND_ACK: if (i == 1) chk_pad(b);
      KIND_QUIT: if (i >= 1 && i <= 3) chk_pad(b);
      KIND_JOIN: if (i == 2 || i == 3) chk_pad(b);
      KIND_SLIST: begin
        if (i == 1) chk_pad(b);
        if (i == 2) recs_left = b << 8;
        if (i == 3) begin
          recs_left |= b;
          if (recs_left == 0) recs_done = 1;
        end
        if (i >= 4 && !recs_done && recs_left != 0) begin
          if (i == rec_start + 7) rec_nlen = b;
          if (i >= rec_start + 7) begin
            a = rec_start + 8 + rec_nlen;
            e = a + pad_count(rec_nlen);
            if (i >= a && i < e) chk_pad(b);
            if (i + 1 == e) begin
              rec_start = e;
              recs_left = (recs_left - 1) & 16'hFFFF;
              if (recs_left == 0) recs_done = 1;
            end
          end
        end
      end
      KIND_MESS: begin
        if (i == 1 || i == 6 || i == 7) chk_pad(b);
        if (i == 2) len_b = b;
        if (i == 4) len_a = b << 8;
        if (i == 5) len_a |= b;
        if (i >= 12) begin
          a = 12 + len_a;
          e = a + pad_count(len_a);
          if (i >= a && i < e) chk_pad(b);
          if (i >= e + len_b) chk_pad(b);
        end
      end
      KIND_PJOIN: begin
        if (i == 1) len_a = b;
        if (i == 2 || i == 3) chk_pad(b);
        if (i >= 2 && i >= 8 + len_a) chk_pad(b);
      end
      KIND_PART: begin
        if (i == 1) len_b = b;
        if (i == 2) len_a = b << 8;
        if (i == 3) len_a |= b;
        if (i == 4 && b == pad_q && len_b > 0) bad = 1;
        if (i >= 4) begin
          if (i < 4 + len_a) begin
            if (b == pad_q) begin
              if (names < 511) names++;
              if (last_pad) bad = 1;
              last_pad = 1;
            end else last_pad = 0;
          end else chk_pad(b);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit judge();
    int unsigned n = n_bytes;
    if (bad) return 0;
    case (pdu_kind)
      KIND_ACK, KIND_QUIT: return n == 4;
      KIND_JOIN: return n >= 4;
      KIND_SLIST: return n >= 4 && recs_done;
      KIND_MESS: return n >= 16 && sum255 == 0 &&
                        n == 12 + len_a + pad_count(len_a) + len_b + pad_count(len_b);
      KIND_PJOIN: return n >= 2 && n == 8 + len_a + pad_count(len_a);
      KIND_PART: return n >= 4 && n == 4 + len_a + pad_count(len_a) && names == len_b;
      default: return 0;
    endcase
  endfunction

  function automatic void predict_byte(logic [2:0] f, logic [7:0] b, bit lst);
    int unsigned i = n_bytes;
    if (i == 0) begin
      clear_pdu();
      pdu_kind = kind_e'(f);
    end
    if (i >= MaxPduBytes) bad = 1;
    else begin
      absorb(i, b);
      n_bytes = i + 1;
    end
    if (lst) begin
      verdict_q.push_back(judge());
      clear_pdu();
    end
  endfunction

  // sink: random backpressure bursts, checks each verdict
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict %0d", $time, m_tdata[0]);
        errors = 1;
      end else begin
        bit exp_v;
        exp_v = verdict_q.pop_front();
        if (m_tdata !== {7'd0, exp_v}) begin
          $display("%0t: verdict mismatch expected %0d actual %0d", $time, exp_v, m_tdata);
          errors = 1;
        end
      end
    end
  end

  initial begin : sink_ready
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : watchdog
    wait (cycles > 600000);
    $display("chat_pdu_validator regression: fail");
    $finish;
  end

  task automatic send_byte(logic [2:0] f, logic [7:0] b, bit lst);
    if (!quiet && $urandom_range(0, 15) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= f;
    s_tlast <= lst;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_byte(f, b, lst);
  endtask

  // send the assembled PDU; the kind rides on the first byte, tuser is random on the rest
  task automatic send_pdu(kind_e k);
    foreach (pdu[j])
      send_byte(j == 0 ? 3'(k) : 3'($urandom), pdu[j], j == pdu.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_pad(logic [7:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pad_q = v;
  endtask

  function automatic logic [7:0] nonpad();
    logic [7:0] v;
    do v = 8'($urandom); while (v == pad_q);
    return v;
  endfunction

  function automatic void add_pads(int unsigned n);
    repeat (n) pdu.push_back(pad_q);
  endfunction

  // build a well-formed PDU of kind k, random content
  function automatic void build_good(kind_e k);
    int unsigned la, lb, r, nl, s;
    pdu.delete();
    pdu.push_back(8'($urandom));
    case (k)
      KIND_ACK, KIND_QUIT: add_pads(3);
      KIND_JOIN: begin
        pdu.push_back(8'($urandom)); add_pads(2);
        repeat ($urandom_range(0, 8)) pdu.push_back(8'($urandom));
      end
      KIND_SLIST: begin
        r = $urandom_range(0, 3);
        add_pads(1); pdu.push_back(8'(r >> 8)); pdu.push_back(8'(r));
        repeat (r) begin
          repeat (7) pdu.push_back(8'($urandom));
          nl = $urandom_range(0, 9);
          pdu.push_back(8'(nl));
          repeat (nl) pdu.push_back(8'($urandom));
          add_pads(pad_count(nl));
        end
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 5)) pdu.push_back(8'($urandom));
      end
      KIND_MESS: begin
        la = $urandom_range(0, 12); lb = $urandom_range(0, 9);
        add_pads(1); pdu.push_back(8'(lb)); pdu.push_back(8'($urandom));
        pdu.push_back(8'(la >> 8)); pdu.push_back(8'(la)); add_pads(2);
        repeat (4) pdu.push_back(8'($urandom));
        repeat (la) pdu.push_back(8'($urandom));
        add_pads(pad_count(la));
        repeat (lb) pdu.push_back(8'($urandom));
        add_pads(pad_count(lb));
        // fix checksum through byte 3, which no rule constrains
        s = 0;
        foreach (pdu[j]) s = (s + pdu[j]) % 255;
        pdu[3] = 8'((pdu[3] + 255 - s) % 255);
      end
      KIND_PJOIN: begin
        la = $urandom_range(0, 10);
        pdu.push_back(8'(la)); add_pads(2);
        repeat (4 + la) pdu.push_back(8'($urandom));
        add_pads(pad_count(la));
      end
      KIND_PART: begin
        nl = $urandom_range(0, 5); la = 0;
        pdu.push_back(8'd0); pdu.push_back(8'd0); pdu.push_back(8'd0);
        repeat (nl) begin
          repeat ($urandom_range(1, 4)) begin pdu.push_back(nonpad()); la++; end
          pdu.push_back(pad_q); la++;
        end
        pdu[1] = 8'(nl); pdu[2] = 8'(la >> 8); pdu[3] = 8'(la);
        add_pads(pad_count(la));
      end
      default: repeat ($urandom_range(1, 8)) pdu.push_back(8'($urandom));
    endcase
  endfunction

  function automatic void corrupt();
    int unsigned p;
    case ($urandom_range(0, 3))
      0: begin p = $urandom_range(0, pdu.size() - 1); pdu[p] = 8'($urandom); end
      1: if (pdu.size() > 1) void'(pdu.pop_back());
      2: pdu.push_back(8'($urandom));
      default: begin p = $urandom_range(0, pdu.size() - 1); pdu[p] = pdu[p] ^ 8'h01; end
    endcase
  endfunction

  task automatic test_directed();
    for (int k = 0; k < 8; k++) begin
      build_good(kind_e'(k));
      send_pdu(kind_e'(k));
    end
    // empty-ish: single byte PDUs of every extreme
    pdu.delete(); pdu.push_back(8'hFF); send_pdu(KIND_JOIN);
    pdu.delete(); pdu.push_back(8'h00); send_pdu(KIND_UNK);
    // participants with a double pad
    pdu.delete();
    pdu = '{8'h00, 8'h02, 8'h00, 8'h04, 8'h41, pad_q, pad_q, 8'h42};
    send_pdu(KIND_PART);
    // unsigned long lengths in mess and pjoin
    pdu.delete(); pdu = '{8'h0, pad_q, 8'hFF, 8'h0, 8'hFF, 8'hFF, pad_q, pad_q};
    send_pdu(KIND_MESS);
    pdu.delete(); pdu = '{8'h0, 8'hFF, pad_q, pad_q}; send_pdu(KIND_PJOIN);
  endtask

  task automatic test_random(int unsigned n_pdus);
    int unsigned k;
    repeat (n_pdus) begin
      k = $urandom_range(0, 7);
      build_good(kind_e'(k));
      if ($urandom_range(0, 3) == 0) corrupt();
      send_pdu(kind_e'(k));
    end
  endtask

  initial begin
    pad_q = '0;
    clear_pdu();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_pad(8'hFF);
    test_directed();
    test_random(12);
    write_pad(8'($urandom_range(1, 254)));
    test_random(18);
    write_pad(8'h00);
    test_random(12);
    quiet = 1;
    test_random(9);
    drain();
    if (!errors) $display("chat_pdu_validator regression: pass");
    else $display("chat_pdu_validator regression: fail");
    $finish;
  end
endmodule
